>>> hdl/bse_pkg.sv
// Shared types, op codes and sizing constants for the bit set engine.
// No dependencies; every other file in hdl/ imports this package.
package bse_pkg;

  // Default capacity of the set in bits
  localparam int SET_BITS_DEF = 256;

  // Field widths
  localparam int OP_W    = 4;
  localparam int IDX_W   = 8;
  localparam int WIDX_W  = 5;
  localparam int DATA_W  = 8;
  localparam int SIZE_W  = 9;
  localparam int POS_W   = 9;

  // Bits reachable through an 8-bit index, and words reachable through a 5-bit word index
  localparam int VIEW_BITS  = 256;
  localparam int VIEW_WORDS = 32;

  // Search answer when nothing is found
  localparam logic [POS_W-1:0] POS_NONE = 9'd256;

  // Active size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET        = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd1;
  localparam logic [OP_W-1:0] OP_TEST       = 4'd2;
  localparam logic [OP_W-1:0] OP_FIRST_SET  = 4'd3;
  localparam logic [OP_W-1:0] OP_FIRST_CLR  = 4'd4;
  localparam logic [OP_W-1:0] OP_ALL_SET    = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 4'd6;
  localparam logic [OP_W-1:0] OP_AND        = 4'd7;
  localparam logic [OP_W-1:0] OP_OR         = 4'd8;
  localparam logic [OP_W-1:0] OP_XOR        = 4'd9;
  localparam logic [OP_W-1:0] OP_SUB        = 4'd10;
  localparam logic [OP_W-1:0] OP_COMPARE    = 4'd11;

  // One input item
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  bit_index;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] word_data;
    logic [SIZE_W-1:0] operand_size;
  } item_t;

  // One result item
  typedef struct packed {
    logic             flag;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

>>> hdl/bse_in_stage.sv
// Input register of the bit set engine: captures one item per transfer.
// Depends on bse_pkg for item_t.
module bse_in_stage
  import bse_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Accept when empty or when the held item moves on this cycle
  assign in_stall = valid_r & ~advance;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on a transfer
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> hdl/bse_exec.sv
// Bit store and single-pass op logic: computes one result and the next store value.
// Depends on bse_pkg for item_t, result_t, op codes and sizes.
module bse_exec
  import bse_pkg::*;
#(
  parameter int SET_BITS = SET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  item_t             item,
  input  logic [SIZE_W-1:0] active_size,
  output result_t           result
);

  localparam int WORD_COUNT  = (SET_BITS + 7) / 8;
  localparam int STORE_WORDS = (WORD_COUNT < VIEW_WORDS) ? WORD_COUNT : VIEW_WORDS;
  localparam int STORE_BITS  = STORE_WORDS * 8;
  localparam int SIZE_CAP_I  = (SET_BITS < 511) ? SET_BITS : 511;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SIZE_CAP_I);

  logic [STORE_BITS-1:0] store_r;
  logic [STORE_BITS-1:0] store_nxt;

  logic [VIEW_BITS-1:0] full;
  logic [VIEW_BITS-1:0] full_nxt;
  logic [VIEW_BITS-1:0] in_size;
  logic [VIEW_BITS-1:0] at_or_above;
  logic [VIEW_BITS-1:0] cand;
  logic [VIEW_BITS-1:0] lowest;
  logic [IDX_W-1:0]     enc;
  logic                 found;
  logic [SIZE_W-1:0]    size;
  logic                 idx_ok;
  logic [DATA_W-1:0]    old_w;
  logic [DATA_W-1:0]    mask_w;
  logic [DATA_W-1:0]    res_w;
  logic                 size_match;

  // Widen the store to the reachable 256-bit view, zero past the store
  generate
    if (STORE_BITS < VIEW_BITS) begin : g_pad
      assign full = {{(VIEW_BITS - STORE_BITS){1'b0}}, store_r};
    end else begin : g_nopad
      assign full = store_r;
    end
  endgenerate

  // Effective size is the active size limited to the capacity
  assign size = (active_size > SIZE_CAP) ? SIZE_CAP : active_size;

  // Per-bit range masks
  always_comb begin
    for (int i = 0; i < VIEW_BITS; i++) begin
      in_size[i]     = (SIZE_W'(i) < size);
      at_or_above[i] = (IDX_W'(i) >= item.bit_index);
    end
  end

  // Search: isolate lowest candidate and encode it
  assign cand   = ((item.op == OP_FIRST_SET) ? full : ~full) & in_size & at_or_above;
  assign found  = |cand;
  assign lowest = cand & (~cand + VIEW_BITS'(1));

  always_comb begin
    enc = '0;
    for (int i = 0; i < VIEW_BITS; i++) begin
      enc = enc | ({IDX_W{lowest[i]}} & IDX_W'(i));
    end
  end

  // Word operand path
  assign idx_ok     = in_size[item.bit_index];
  assign old_w      = full[{item.word_index, 3'b000} +: DATA_W];
  assign mask_w     = in_size[{item.word_index, 3'b000} +: DATA_W];
  assign size_match = (item.operand_size == active_size);

  always_comb begin
    case (item.op)
      OP_AND:  res_w = old_w & item.word_data;
      OP_OR:   res_w = old_w | item.word_data;
      OP_XOR:  res_w = old_w ^ item.word_data;
      default: res_w = old_w & ~item.word_data;
    endcase
  end

  // Decode op: result and next store image
  always_comb begin
    full_nxt        = full;
    result.flag     = 1'b0;
    result.position = '0;
    unique case (item.op)
      OP_SET: begin
        if (idx_ok) full_nxt[item.bit_index] = 1'b1;
      end
      OP_CLEAR: begin
        if (idx_ok) full_nxt[item.bit_index] = 1'b0;
      end
      OP_TEST: begin
        result.flag = idx_ok & full[item.bit_index];
      end
      OP_FIRST_SET, OP_FIRST_CLR: begin
        result.flag     = found;
        result.position = found ? {1'b0, enc} : POS_NONE;
      end
      OP_ALL_SET: begin
        // Bits past the reachable view are never set
        result.flag = (&(full | ~in_size)) & (size <= SIZE_W'(VIEW_BITS));
      end
      OP_CLEAR_ALL: begin
        full_nxt = '0;
      end
      OP_AND, OP_OR, OP_XOR, OP_SUB: begin
        if (size_match) begin
          full_nxt[{item.word_index, 3'b000} +: DATA_W] = (res_w & mask_w) | (old_w & ~mask_w);
        end
      end
      OP_COMPARE: begin
        result.flag = size_match & ((old_w & mask_w) == (item.word_data & mask_w));
      end
      default: begin
        full_nxt = full;
      end
    endcase
  end

  assign store_nxt = full_nxt[STORE_BITS-1:0];

  // Advance the store when the item retires into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
    end else if (fire) begin
      store_r <= store_nxt;
    end
  end

endmodule

>>> hdl/bse_out_stage.sv
// Result register of the bit set engine: holds one result until its transfer.
// Depends on bse_pkg for result_t.
module bse_out_stage
  import bse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // Room for a new result when empty or when the held one transfers now
  assign advance = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (~out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= load_result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

>>> hdl/bitset_engine.sv
// Top level of the bit set engine: config register, input stage, executor, result stage.
// Depends on bse_pkg, bse_in_stage, bse_exec and bse_out_stage.
//
//   channel | ports                                              | handshake
//   --------+----------------------------------------------------+------------------
//   input   | in_op in_bit_index in_word_index in_word_data      | in_valid/in_stall
//           | in_operand_size                                    |
//   result  | out_flag out_position                              | out_valid/out_stall
//   config  | cfg_wr_data                                        | cfg_wr_en
//
// One item per cycle sustained while the result side does not stall; an accepted item is
// held in the input register and then loaded into the result register.
// The store updates in the same edge that loads the result register, so the next item
// sees it with no bubble. Reset clears the whole store and sets the active size to 256.
// A stalled result holds the input register, which then stalls the input side.
module bitset_engine
  import bse_pkg::*;
#(
  parameter int SET_BITS = SET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [SIZE_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_op,
  input  logic [IDX_W-1:0]    in_bit_index,
  input  logic [WIDX_W-1:0]   in_word_index,
  input  logic [DATA_W-1:0]   in_word_data,
  input  logic [SIZE_W-1:0]   in_operand_size,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_flag,
  output logic [POS_W-1:0]    out_position
);

  logic [SIZE_W-1:0] active_size_r;
  item_t             in_item;
  item_t             s1_item;
  logic              s1_valid;
  logic              advance;
  logic              fire;
  result_t           exec_result;
  result_t           out_result;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      active_size_r <= cfg_wr_data;
    end
  end

  assign in_item.op           = in_op;
  assign in_item.bit_index    = in_bit_index;
  assign in_item.word_index   = in_word_index;
  assign in_item.word_data    = in_word_data;
  assign in_item.operand_size = in_operand_size;

  bse_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Retire the held item into the result register
  assign fire = s1_valid & advance;

  bse_exec #(
    .SET_BITS (SET_BITS)
  ) u_exec (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (s1_item),
    .active_size (active_size_r),
    .result      (exec_result)
  );

  bse_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (fire),
    .load_result (exec_result),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  assign out_flag     = out_result.flag;
  assign out_position = out_result.position;

endmodule

>>> dv/bitset_engine_tb.sv
// Self-checking testbench for bitset_engine: random and directed operations
// checked against an in-bench shadow of the bit set. Depends on bse_pkg.
`timescale 1ns / 1ps

module bitset_engine_tb;
  import bse_pkg::*;

  // Op codes past the defined set; the block must ignore them
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd12;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG    = 3000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = '0;
  logic [IDX_W-1:0]  in_bit_index = '0;
  logic [WIDX_W-1:0] in_word_index = '0;
  logic [DATA_W-1:0] in_word_data = '0;
  logic [SIZE_W-1:0] in_operand_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_flag;
  logic [POS_W-1:0]  out_position;

  // Items waiting to be sent, and answers waiting to come back
  item_t   op_backlog[$];
  result_t answers_due[$];

  // Shadow of the set and of the active size register
  logic [VIEW_BITS-1:0] shadow_bits = '0;
  logic [SIZE_W-1:0]    shadow_size = SIZE_RESET;

  int gap_pct   = 38;
  int stall_pct = 38;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors    = 0;
  int quiet_cycles = 0;

  bitset_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_bit_index   (in_bit_index),
    .in_word_index  (in_word_index),
    .in_word_data   (in_word_data),
    .in_operand_size(in_operand_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_flag       (out_flag),
    .out_position   (out_position)
  );

  always #1 clk = ~clk;

  // Apply one operation to the shadow set and return its answer
  function automatic result_t bitset_apply(item_t it);
    result_t     r;
    int unsigned sz;
    int unsigned wi;
    int unsigned b;
    logic        want;
    logic [7:0]  m;
    logic [7:0]  old;
    logic [7:0]  res;
    r = '0;
    sz = (shadow_size > VIEW_BITS) ? VIEW_BITS : shadow_size;
    wi = it.word_index;
    case (it.op)
      OP_SET: if (it.bit_index < sz) shadow_bits[it.bit_index] = 1'b1;
      OP_CLEAR: if (it.bit_index < sz) shadow_bits[it.bit_index] = 1'b0;
      OP_TEST: r.flag = (it.bit_index < sz) && shadow_bits[it.bit_index];
      OP_FIRST_SET, OP_FIRST_CLR: begin
        want = (it.op == OP_FIRST_SET);
        r.position = POS_NONE;
        for (b = it.bit_index; b < sz; b++) begin
          if (!r.flag && shadow_bits[b] == want) begin
            r.flag = 1'b1;
            r.position = POS_W'(b);
          end
        end
      end
      OP_ALL_SET: begin
        r.flag = 1'b1;
        for (b = 0; b < sz; b++)
          if (!shadow_bits[b]) r.flag = 1'b0;
      end
      OP_CLEAR_ALL: shadow_bits = '0;
      OP_AND, OP_OR, OP_XOR, OP_SUB, OP_COMPARE: begin
        if (it.operand_size == shadow_size) begin
          for (b = 0; b < 8; b++) m[b] = (wi * 8 + b < sz);
          old = shadow_bits[wi*8 +: 8];
          case (it.op)
            OP_AND:  res = old & it.word_data;
            OP_OR:   res = old | it.word_data;
            OP_XOR:  res = old ^ it.word_data;
            default: res = old & ~it.word_data;
          endcase
          if (it.op == OP_COMPARE)
            r.flag = ((old & m) == (it.word_data & m));
          else
            shadow_bits[wi*8 +: 8] = (res & m) | (old & ~m);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(logic [OP_W-1:0] op, int unsigned idx, int unsigned wi,
                                    int unsigned data, int unsigned osz);
    item_t it;
    it.op = op;
    it.bit_index = IDX_W'(idx);
    it.word_index = WIDX_W'(wi);
    it.word_data = DATA_W'(data);
    it.operand_size = SIZE_W'(osz);
    return it;
  endfunction

  // Random item, biased toward in-range indices and a matching operand size
  function automatic item_t rand_item(int unsigned sz);
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.bit_index = IDX_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, sz - 1)
                                                       : $urandom_range(0, 255));
    it.word_index = WIDX_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, (sz - 1) / 8)
                                                         : $urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0: it.word_data = 8'hFF;
      1: it.word_data = 8'h00;
      default: it.word_data = DATA_W'($urandom_range(0, 255));
    endcase
    it.operand_size = SIZE_W'(($urandom_range(0, 5) != 0) ? sz : $urandom_range(1, 256));
    if (pick < 24)      it.op = OP_SET;
    else if (pick < 34) it.op = OP_CLEAR;
    else if (pick < 44) it.op = OP_TEST;
    else if (pick < 54) it.op = OP_FIRST_SET;
    else if (pick < 64) it.op = OP_FIRST_CLR;
    else if (pick < 69) it.op = OP_ALL_SET;
    else if (pick < 71) it.op = OP_CLEAR_ALL;
    else if (pick < 89) it.op = OP_W'(OP_AND + $urandom_range(0, 3));
    else if (pick < 97) it.op = OP_COMPARE;
    else                it.op = OP_W'(OP_UNUSED_LO + $urandom_range(0, 3));
    return it;
  endfunction

  task automatic wait_drained();
    while (op_backlog.size() != 0 || answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the active size while nothing is in flight
  task automatic load_size(int unsigned sz);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= SIZE_W'(sz);
    shadow_size = SIZE_W'(sz);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) op_backlog.push_back(rand_item(shadow_size));
  endtask

  // Driver: advance on transfer, hold while stalled, idle at random
  always @(posedge clk) begin : drive
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        answers_due.push_back(bitset_apply(op_backlog[0]));
        void'(op_backlog.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (op_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_op <= op_backlog[0].op;
          in_bit_index <= op_backlog[0].bit_index;
          in_word_index <= op_backlog[0].word_index;
          in_word_data <= op_backlog[0].word_data;
          in_operand_size <= op_backlog[0].operand_size;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then pick the next stall
  always @(posedge clk) begin : receive
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got flag %0b position %0d", $time,
                   out_flag, out_position);
        end else begin
          want = answers_due.pop_front();
          if (want.flag !== out_flag) begin
            errors++;
            $display("%0t: flag mismatch, expected %0b, got %0b", $time, want.flag, out_flag);
          end
          if (want.position !== out_position) begin
            errors++;
            $display("%0t: position mismatch, expected %0d, got %0d", $time, want.position,
                     out_position);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: count cycles with work outstanding but no transfer
  always @(posedge clk) begin
    if (rst_n && (op_backlog.size() != 0 || answers_due.size() != 0) &&
        !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  initial begin : stim
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full size: edges of the index range, searches, word ops, size mismatch
    load_size(256);
    op_backlog.push_back(mk_item(OP_SET, 0, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_SET, 255, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_TEST, 255, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_TEST, 128, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_FIRST_SET, 1, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_FIRST_CLR, 0, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_CLEAR, 255, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_FIRST_SET, 1, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_OR, 0, 31, 8'hFF, 256));
    op_backlog.push_back(mk_item(OP_AND, 0, 31, 8'h0F, 256));
    op_backlog.push_back(mk_item(OP_XOR, 0, 0, 8'hAA, 256));
    op_backlog.push_back(mk_item(OP_SUB, 0, 0, 8'h0F, 256));
    op_backlog.push_back(mk_item(OP_COMPARE, 0, 0, 8'hA0, 256));
    op_backlog.push_back(mk_item(OP_COMPARE, 0, 0, 8'hA0, 1));
    op_backlog.push_back(mk_item(OP_OR, 0, 1, 8'hFF, 255));
    op_backlog.push_back(mk_item(OP_ALL_SET, 0, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_FIRST_CLR, 255, 0, 0, 256));
    op_backlog.push_back(mk_item(OP_W'(OP_UNUSED_LO + 3), 255, 31, 8'hFF, 256));
    op_backlog.push_back(mk_item(OP_CLEAR_ALL, 0, 0, 0, 256));
    queue_random(110);

    // Size 9: index past the size, partial and empty word masks, full set
    load_size(9);
    op_backlog.push_back(mk_item(OP_SET, 200, 0, 0, 9));
    op_backlog.push_back(mk_item(OP_TEST, 200, 0, 0, 9));
    op_backlog.push_back(mk_item(OP_OR, 0, 0, 8'hFF, 9));
    op_backlog.push_back(mk_item(OP_OR, 0, 1, 8'hFF, 9));
    op_backlog.push_back(mk_item(OP_ALL_SET, 0, 0, 0, 9));
    op_backlog.push_back(mk_item(OP_OR, 0, 5, 8'hFF, 9));
    op_backlog.push_back(mk_item(OP_COMPARE, 0, 5, 8'h5A, 9));
    op_backlog.push_back(mk_item(OP_FIRST_CLR, 0, 0, 0, 9));
    queue_random(110);

    load_size(1);
    queue_random(110);

    // No idling on either side
    load_size(255);
    gap_pct = 0;
    stall_pct = 0;
    queue_random(150);

    // Long receiver hold-off while the sender keeps offering
    load_size(64);
    gap_pct = 0;
    stall_pct = 38;
    queue_random(110);
    hold_req++;

    load_size($urandom_range(2, 254));
    gap_pct = 38;
    queue_random(110);

    load_size(8);
    queue_random(110);

    load_size(256);
    queue_random(150);

    wait_drained();
    repeat (10) @(posedge clk);
    if (answers_due.size() != 0) errors++;
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/bse_pkg.sv
hdl/bse_in_stage.sv
hdl/bse_exec.sv
hdl/bse_out_stage.sv
hdl/bitset_engine.sv
dv/bitset_engine_tb.sv
